[rtl/bpc_pkg.sv]
// Shared types, widths and codes for the barometric pressure compensation unit.
package bpc_pkg;

	// Field widths
	localparam int RAW_W = 24;
	localparam int CAL_W = 16;
	localparam int VAL_W = 32;
	localparam int CFG_IDX_W = 3;

	// Internal datapath widths; every value range fits without wrapping.
	localparam int DT_W = RAW_W + 1;
	localparam int MUL_A_W = DT_W;
	localparam int MUL_B_W = 18;
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int OFF_W = 35;
	localparam int SENS_W = 34;
	localparam int SENS_SPLIT = 17;
	localparam int ACC_W = PROD_W + SENS_SPLIT;

	// Compensation constants
	localparam int TEMP_BASE = 2000;
	localparam int TEMP_SHIFT = 23;
	localparam int OFF_BASE_SHIFT = 16;
	localparam int OFF_SHIFT = 7;
	localparam int SENS_BASE_SHIFT = 15;
	localparam int SENS_SHIFT = 8;
	localparam int PRES_SHIFT = 21;
	localparam int FINAL_SHIFT = 15;

	// Calibration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_C1 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_C2 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_C3 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_C4 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_C5 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_C6 = 3'd5;

	// Operand selection of the shared multiplier
	typedef enum logic [2:0] {
		MUL_SLOPE     = 3'd0,
		MUL_OFF_COEF  = 3'd1,
		MUL_SENS_COEF = 3'd2,
		MUL_SENS_LO   = 3'd3,
		MUL_SENS_HI   = 3'd4
	} mul_sel_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic     load_in;
		logic     load_dt;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     load_temp;
		logic     load_off;
		logic     load_sens;
		logic     load_acc;
		logic     add_acc;
		logic     load_pres;
		logic     load_out;
		logic     out_kind;
		logic     out_updated;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic out_busy;
	} stat_t;

endpackage

[rtl/barometric_pressure_compensation_unit.sv]
// Top level of the barometric pressure compensation unit.
//
//   channel  signals                                  direction
//   in       in_valid/in_ready, raw_conversion,       request in
//            read_ok
//   out      out_valid/out_ready, quantity,           request out
//            compensated_value, updated
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data write in
//
// One request is processed at a time: a temperature request passes the difference,
// multiply and final states, a pressure request the offset and sensitivity multiplies,
// the sensitivity load, two partial products, accumulate and final, a failed read none;
// the shared 25 x 18 multiplier, used by one step at a time, sets the sequence length.
// Reset clears the phase, the calibration words and the kept values to zero.
// A result waits in the output register while the next request is accepted;
// a stalled output holds the following result back and blocks further requests.
module barometric_pressure_compensation_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [bpc_pkg::RAW_W-1:0]        raw_conversion,
	input  logic                             read_ok,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             quantity,
	output logic signed [bpc_pkg::VAL_W-1:0] compensated_value,
	output logic                             updated,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bpc_pkg::CAL_W-1:0]        cfg_data
);
	import bpc_pkg::*;

	cmd_t  cmd;
	stat_t status;

	// Calibration writes are always taken.
	assign cfg_ready = 1'b1;

	bpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.read_ok  (read_ok),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	bpc_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.raw_conversion    (raw_conversion),
		.cmd               (cmd),
		.status            (status),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.quantity          (quantity),
		.compensated_value (compensated_value),
		.updated           (updated)
	);

endmodule

[rtl/bpc_ctrl.sv]
// Controller state machine that sequences temperature and pressure compensation.
module bpc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            read_ok,
	output logic            in_ready,
	input  bpc_pkg::stat_t  status,
	output bpc_pkg::cmd_t   cmd
);
	import bpc_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE       = 12'b0000_0000_0001,
		ST_T_DIFF     = 12'b0000_0000_0010,
		ST_T_MUL      = 12'b0000_0000_0100,
		ST_T_FIN      = 12'b0000_0000_1000,
		ST_P_OFF_MUL  = 12'b0000_0001_0000,
		ST_P_SENS_MUL = 12'b0000_0010_0000,
		ST_P_SENS     = 12'b0000_0100_0000,
		ST_P_LO_MUL   = 12'b0000_1000_0000,
		ST_P_HI_MUL   = 12'b0001_0000_0000,
		ST_P_ACC      = 12'b0010_0000_0000,
		ST_P_FIN      = 12'b0100_0000_0000,
		ST_RESULT     = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   expect_pressure_q;
	logic   kind_q;
	logic   ok_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;

	// Phase and per-request flags are captured when a request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			expect_pressure_q <= 1'b0;
			kind_q            <= 1'b0;
			ok_q              <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				expect_pressure_q <= ~expect_pressure_q;
				kind_q            <= expect_pressure_q;
				ok_q              <= read_ok;
			end
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.mul_sel     = MUL_SLOPE;
		cmd.out_kind    = kind_q;
		cmd.out_updated = ok_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					if (!read_ok) begin
						state_d = ST_RESULT;
					end else if (expect_pressure_q) begin
						state_d = ST_P_OFF_MUL;
					end else begin
						state_d = ST_T_DIFF;
					end
				end
			end
			ST_T_DIFF: begin
				cmd.load_dt = 1'b1;
				state_d     = ST_T_MUL;
			end
			ST_T_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SLOPE;
				state_d     = ST_T_FIN;
			end
			ST_T_FIN: begin
				cmd.load_temp = 1'b1;
				state_d       = ST_RESULT;
			end
			ST_P_OFF_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_OFF_COEF;
				state_d     = ST_P_SENS_MUL;
			end
			ST_P_SENS_MUL: begin
				cmd.load_off = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_SENS_COEF;
				state_d      = ST_P_SENS;
			end
			ST_P_SENS: begin
				cmd.load_sens = 1'b1;
				state_d       = ST_P_LO_MUL;
			end
			ST_P_LO_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SENS_LO;
				state_d     = ST_P_HI_MUL;
			end
			ST_P_HI_MUL: begin
				cmd.load_acc = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_SENS_HI;
				state_d      = ST_P_ACC;
			end
			ST_P_ACC: begin
				cmd.add_acc = 1'b1;
				state_d     = ST_P_FIN;
			end
			ST_P_FIN: begin
				cmd.load_pres = 1'b1;
				state_d       = ST_RESULT;
			end
			ST_RESULT: begin
				if (!status.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/bpc_datapath.sv]
// Datapath: calibration registers, shared multiplier, compensation state and output register.
module bpc_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bpc_pkg::CAL_W-1:0]       cfg_data,
	input  logic [bpc_pkg::RAW_W-1:0]       raw_conversion,
	input  bpc_pkg::cmd_t                   cmd,
	output bpc_pkg::stat_t                  status,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            quantity,
	output logic signed [bpc_pkg::VAL_W-1:0] compensated_value,
	output logic                            updated
);
	import bpc_pkg::*;

	logic [CAL_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
	logic [RAW_W-1:0] raw_q;
	logic signed [DT_W-1:0]    dt_q;
	logic signed [VAL_W-1:0]   held_temp_q;
	logic signed [VAL_W-1:0]   held_pres_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [OFF_W-1:0]   off_q;
	logic signed [SENS_W-1:0]  sens_q;
	logic signed [ACC_W-1:0]   acc_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_d;
	logic signed [DT_W-1:0]    dt_d;
	logic signed [PROD_W-1:0]  temp_full;
	logic signed [PROD_W-1:0]  off_prod;
	logic signed [PROD_W-1:0]  sens_prod;
	logic signed [OFF_W-1:0]   off_d;
	logic signed [SENS_W-1:0]  sens_d;
	logic signed [ACC_W-1:0]   prod_ext;
	logic signed [ACC_W-1:0]   off_ext;
	logic signed [ACC_W-1:0]   pres_diff;
	logic signed [ACC_W-1:0]   pres_full;

	// Calibration register writes; indexes past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0;
			c2_q <= '0;
			c3_q <= '0;
			c4_q <= '0;
			c5_q <= '0;
			c6_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_C1:  c1_q <= cfg_data;
				REG_C2:  c2_q <= cfg_data;
				REG_C3:  c3_q <= cfg_data;
				REG_C4:  c4_q <= cfg_data;
				REG_C5:  c5_q <= cfg_data;
				REG_C6:  c6_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Shared multiplier operand selection.
	always_comb begin
		case (cmd.mul_sel)
			MUL_SLOPE: begin
				mul_a = dt_q;
				mul_b = $signed({2'b00, c6_q});
			end
			MUL_OFF_COEF: begin
				mul_a = dt_q;
				mul_b = $signed({2'b00, c4_q});
			end
			MUL_SENS_COEF: begin
				mul_a = dt_q;
				mul_b = $signed({2'b00, c3_q});
			end
			MUL_SENS_LO: begin
				mul_a = $signed({1'b0, raw_q});
				mul_b = $signed({1'b0, sens_q[SENS_SPLIT-1:0]});
			end
			MUL_SENS_HI: begin
				mul_a = $signed({1'b0, raw_q});
				mul_b = $signed({sens_q[SENS_W-1], sens_q[SENS_W-1:SENS_SPLIT]});
			end
			default: begin
				mul_a = dt_q;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;

	// Temperature difference and compensated temperature.
	assign dt_d      = $signed({1'b0, raw_q}) - $signed({1'b0, c5_q, 8'h00});
	assign temp_full = (prod_q >>> TEMP_SHIFT) + $signed(PROD_W'(TEMP_BASE));

	// Offset and sensitivity at the current temperature.
	assign off_prod  = prod_q >>> OFF_SHIFT;
	assign sens_prod = prod_q >>> SENS_SHIFT;
	assign off_d  = $signed({3'b000, c2_q, {OFF_BASE_SHIFT{1'b0}}})
		+ $signed(off_prod[OFF_W-1:0]);
	assign sens_d = $signed({3'b000, c1_q, {SENS_BASE_SHIFT{1'b0}}})
		+ $signed(sens_prod[SENS_W-1:0]);

	// Raw pressure times sensitivity is built from two partial products.
	assign prod_ext  = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
	assign off_ext   = {{(ACC_W-OFF_W){off_q[OFF_W-1]}}, off_q};
	assign pres_diff = (acc_q >>> PRES_SHIFT) - off_ext;
	assign pres_full = pres_diff >>> FINAL_SHIFT;

	// Compensation state, reset to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q        <= '0;
			held_temp_q <= '0;
			held_pres_q <= '0;
		end else begin
			if (cmd.load_dt) begin
				dt_q <= dt_d;
			end
			if (cmd.load_temp) begin
				held_temp_q <= temp_full[VAL_W-1:0];
			end
			if (cmd.load_pres) begin
				held_pres_q <= pres_full[VAL_W-1:0];
			end
		end
	end

	// Working registers of the datapath.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			raw_q <= raw_conversion;
		end
		if (cmd.mul_en) begin
			prod_q <= prod_d;
		end
		if (cmd.load_off) begin
			off_q <= off_d;
		end
		if (cmd.load_sens) begin
			sens_q <= sens_d;
		end
		if (cmd.load_acc) begin
			acc_q <= prod_ext;
		end else if (cmd.add_acc) begin
			acc_q <= acc_q + (prod_ext <<< SENS_SPLIT);
		end
	end

	// Output register; it frees up in the same cycle its request is taken.
	assign status.out_busy = out_valid & ~out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			quantity          <= cmd.out_kind;
			updated           <= cmd.out_updated;
			compensated_value <= cmd.out_kind ? held_pres_q : held_temp_q;
		end
	end

endmodule

[rtl/bpc_checker.sv]
// Port-level checker for the compensation unit, bound to the top level.
module bpc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic                             quantity,
	input logic signed [bpc_pkg::VAL_W-1:0] compensated_value,
	input logic                             updated
);
	import bpc_pkg::*;

	logic exp_kind_q;

	// Results alternate between temperature and pressure, temperature first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_kind_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			exp_kind_q <= ~exp_kind_q;
		end
	end

	a_kind_alternates: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> quantity == exp_kind_q)
		else $error("result kind out of order");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a request is in progress");

	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	a_out_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable(quantity) && $stable(compensated_value) && $stable(updated))
		else $error("stalled result changed");

endmodule

bind barometric_pressure_compensation_unit bpc_checker u_bpc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_valid),
	.in_ready          (in_ready),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.quantity          (quantity),
	.compensated_value (compensated_value),
	.updated           (updated)
);

[dv/tb_top.sv]
// Self-checking testbench for the barometric pressure compensation unit.
`timescale 1ns / 100ps

module tb_top;
	import bpc_pkg::*;

	// Result kinds, the register indexes that decode to nothing, field maxima and test lengths.
	localparam logic QTY_TEMP = 1'b0;
	localparam logic QTY_PRES = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
	localparam logic [CAL_W-1:0] CAL_MAX = {CAL_W{1'b1}};
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int RANDOM_PER_PHASE = 340;

	typedef struct {
		logic [RAW_W-1:0] raw;
		logic             ok;
	} conversion_t;

	typedef struct {
		logic                    quantity;
		logic signed [VAL_W-1:0] value;
		logic                    updated;
	} reading_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [RAW_W-1:0]        raw_conversion = '0;
	logic                    read_ok = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    quantity;
	logic signed [VAL_W-1:0] compensated_value;
	logic                    updated;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CAL_W-1:0]        cfg_data = '0;

	// Predictor state: calibration words, phase and kept values.
	logic [CAL_W-1:0] cal_word [0:5];
	logic             expect_pres = 1'b0;
	logic [VAL_W-1:0] kept_dt = '0;
	logic [VAL_W-1:0] kept_temp = '0;
	logic [VAL_W-1:0] kept_pres = '0;

	conversion_t pending_reqs[$];
	reading_t    expected_readings[$];
	int          mismatch_count = 0;
	int          snd_idle_pct = 0;
	int          rcv_idle_pct = 0;
	int          hold_token = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	logic        in_fire = 1'b0;

	barometric_pressure_compensation_unit u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.raw_conversion   (raw_conversion),
		.read_ok          (read_ok),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.quantity         (quantity),
		.compensated_value(compensated_value),
		.updated          (updated),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < 6; i++) begin
			cal_word[i] = '0;
		end
	end

	// Compensate one conversion and advance the predicted phase.
	function automatic reading_t compensate(logic [RAW_W-1:0] raw, logic ok);
		reading_t r;
		longint rw, dt, t, off, sens, p;
		longint c1, c2, c3, c4, c5, c6;
		rw = {40'd0, raw};
		c1 = {48'd0, cal_word[REG_C1]};
		c2 = {48'd0, cal_word[REG_C2]};
		c3 = {48'd0, cal_word[REG_C3]};
		c4 = {48'd0, cal_word[REG_C4]};
		c5 = {48'd0, cal_word[REG_C5]};
		c6 = {48'd0, cal_word[REG_C6]};
		if (!expect_pres) begin
			if (ok) begin
				dt = rw - (c5 <<< 8);
				t = 2000 + ((dt * c6) >>> 23);
				kept_dt = dt[31:0];
				kept_temp = t[31:0];
			end
			r.quantity = QTY_TEMP;
			r.value = kept_temp;
		end else begin
			if (ok) begin
				dt = {{32{kept_dt[31]}}, kept_dt};
				off = (c2 <<< 16) + ((c4 * dt) >>> 7);
				sens = (c1 <<< 15) + ((c3 * dt) >>> 8);
				p = (((rw * sens) >>> 21) - off) >>> 15;
				kept_pres = p[31:0];
			end
			r.quantity = QTY_PRES;
			r.value = kept_pres;
		end
		r.updated = ok;
		expect_pres = !expect_pres;
		return r;
	endfunction

	// Input monitor: predict the result of every accepted request.
	always @(posedge clk) begin
		in_fire <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			expected_readings.push_back(compensate(raw_conversion, read_ok));
		end
	end

	// Request driver: holds a request until accepted, idles at random.
	always @(negedge clk) begin
		conversion_t c;
		if (arst_n && !(in_valid && !in_fire)) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				c = pending_reqs.pop_front();
				raw_conversion <= c.raw;
				read_ok <= c.ok;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random back-pressure and an occasional long hold-off.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_token) begin
			hold_seen <= hold_token;
			hold_left <= LONG_HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// Output monitor: compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		reading_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_readings.size() == 0) begin
				$display("%0t: unexpected result expected none actual quantity=%0d value=%0d updated=%0d",
					$time, quantity, compensated_value, updated);
				mismatch_count = mismatch_count + 1;
			end else begin
				e = expected_readings.pop_front();
				if (quantity !== e.quantity) begin
					$display("%0t: quantity mismatch expected %0d actual %0d",
						$time, e.quantity, quantity);
					mismatch_count = mismatch_count + 1;
				end
				if (compensated_value !== e.value) begin
					$display("%0t: value mismatch expected %0d actual %0d",
						$time, e.value, compensated_value);
					mismatch_count = mismatch_count + 1;
				end
				if (updated !== e.updated) begin
					$display("%0t: updated mismatch expected %0d actual %0d",
						$time, e.updated, updated);
					mismatch_count = mismatch_count + 1;
				end
			end
		end
	end

	// Write one calibration register; the caller lowers cfg_valid afterwards.
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CAL_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= REG_C6) begin
			cal_word[idx] = data;
		end
	endtask

	task automatic cfg_done();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic cfg_all(logic [CAL_W-1:0] c1, logic [CAL_W-1:0] c2,
		logic [CAL_W-1:0] c3, logic [CAL_W-1:0] c4,
		logic [CAL_W-1:0] c5, logic [CAL_W-1:0] c6);
		cfg_write(REG_C1, c1);
		cfg_write(REG_C2, c2);
		cfg_write(REG_C3, c3);
		cfg_write(REG_C4, c4);
		cfg_write(REG_C5, c5);
		cfg_write(REG_C6, c6);
		cfg_done();
	endtask

	// Random calibration words.
	task automatic cfg_random();
		cfg_all(CAL_W'($urandom()), CAL_W'($urandom()), CAL_W'($urandom()),
			CAL_W'($urandom()), CAL_W'($urandom()), CAL_W'($urandom()));
	endtask

	task automatic send(logic [RAW_W-1:0] raw, logic ok);
		conversion_t c;
		c.raw = raw;
		c.ok = ok;
		pending_reqs.push_back(c);
	endtask

	// Wait until every request is taken and every result has arrived.
	task automatic wait_drain();
		while (pending_reqs.size() != 0 || in_valid || expected_readings.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Random requests: mostly good reads, some failed ones and field extremes.
	task automatic send_random(int n);
		logic [RAW_W-1:0] raw;
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 3) begin
				raw = '0;
			end else if (sel < 6) begin
				raw = RAW_MAX;
			end else begin
				raw = RAW_W'($urandom());
			end
			send(raw, $urandom_range(99) >= 10);
		end
	endtask

	// Main sequence.
	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part with typical calibration; spare indexes must be ignored.
		snd_idle_pct = 27;
		rcv_idle_pct = 46;
		cfg_write(REG_SPARE_LO, 16'h1234);
		cfg_write(REG_SPARE_HI, CAL_MAX);
		cfg_all(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
		// Failed temperature read, then pressure before any temperature.
		send(RAW_MAX, 1'b0);
		send(RAW_MAX, 1'b1);
		send('0, 1'b1);
		send('0, 1'b1);
		send(RAW_MAX, 1'b1);
		send(RAW_MAX, 1'b1);
		send(24'd8566784, 1'b1);
		// Failed pressure and temperature reads keep the held values.
		send('0, 1'b0);
		send(24'h555555, 1'b0);
		send(24'hAAAAAA, 1'b1);
		send(24'd8569150, 1'b1);
		send(24'd9085466, 1'b1);
		wait_drain();

		// Largest calibration words.
		cfg_all(CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX);
		send('0, 1'b1);
		send(RAW_MAX, 1'b1);
		send(RAW_MAX, 1'b1);
		send(RAW_MAX, 1'b1);
		wait_drain();

		// All calibration words zero.
		cfg_all('0, '0, '0, '0, '0, '0);
		send(RAW_MAX, 1'b1);
		send(RAW_MAX, 1'b1);
		wait_drain();

		// First random phase: long receiver hold-off and a sender pause.
		cfg_random();
		send_random(RANDOM_PER_PHASE / 2);
		hold_token = hold_token + 1;
		wait_drain();
		send_random(RANDOM_PER_PHASE / 2);
		wait_drain();

		// Second random phase with the idling swapped.
		snd_idle_pct = 46;
		rcv_idle_pct = 27;
		cfg_write(REG_SPARE_HI, CAL_W'($urandom()));
		cfg_all(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
		send_random(RANDOM_PER_PHASE);
		wait_drain();

		// Third random phase with no idling.
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		cfg_random();
		send_random(RANDOM_PER_PHASE);
		wait_drain();

		if (mismatch_count == 0 && expected_readings.size() == 0) begin
			$display("PASS barometric_pressure_compensation_unit");
		end else begin
			$display("FAIL barometric_pressure_compensation_unit");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("FAIL barometric_pressure_compensation_unit");
		$finish;
	end

endmodule
